FILE: design/mme_pkg.sv
// mme_pkg: types, codes and constants of the matrix multiply engine
// no dependencies

package mme_pkg;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int RESULT_W  = 34;
  localparam int FIELD_W   = 2;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_DIM_DEF = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  // action codes of an input item
  localparam logic [1:0] ACT_WRITE_A = 2'd0;
  localparam logic [1:0] ACT_WRITE_B = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic [FIELD_W-1:0]       row;
    logic [FIELD_W-1:0]       col;
    logic signed [ELEM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] product;
    logic [FIELD_W-1:0]         out_row;
    logic [FIELD_W-1:0]         out_col;
    logic                       last;
  } out_item_t;

  // tag that travels with each multiply step down the pipeline
  typedef struct packed {
    logic               first;
    logic               last_k;
    logic               last_el;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
  } step_tag_t;

  typedef enum logic {
    ST_IDLE,
    ST_MAC
  } seq_state_t;

endpackage

FILE: design/matrix_multiply_engine.sv
// matrix_multiply_engine: dense product of two small Q8.8 matrices
// load items fill store_a / store_b, a start item streams out C = A*B row-major
// load items are written to their store when accepted, and loads are accepted back to back
// a start item: each result element takes inner_dim multiply steps, then the
//   pipeline drain and output handoff, paced by the single shared
//   multiply-accumulate unit and the one read port of each store
// in_ready is low from start until the last multiply step is issued
// reset (rst_n, synchronous, active low) clears control state and sets the size
//   registers to 4; store contents stay undefined until written

module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);

  // size registers
  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  // element stores, one write and one read port each
  logic signed [ELEM_W-1:0] store_a [DEPTH];
  logic signed [ELEM_W-1:0] store_b [DEPTH];

  // sequencer
  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, j_r, k_r;
  logic [IDX_W-1:0] i_nxt, j_nxt, k_nxt;
  logic [IDX_W-1:0] ilim_r, jlim_r, klim_r;
  logic [IDX_W-1:0] ilim_nxt, jlim_nxt, klim_nxt;

  // pipeline
  logic                     v1_r, v2_r;
  step_tag_t                tag_issue, tag1_r, tag2_r;
  logic signed [ELEM_W-1:0] rd_a_r, rd_b_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RESULT_W-1:0] acc_r, acc_nxt;

  logic                     out_valid_r;
  out_item_t                out_r;

  logic              accept, issue, in_range;
  logic              wr_a, wr_b;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [IDX_W+1:0]  i_ext, j_ext;

  // clamp a size register to 1..MAX_DIM and return it minus one
  function automatic logic [IDX_W-1:0] dim_limit(input logic [CFG_W-1:0] reg_val);
    logic [IDX_W-1:0] res;
    if (reg_val == '0) begin
      res = '0;
    end else if (int'(reg_val) > MAX_DIM) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(reg_val - CFG_W'(1));
    end
    return res;
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // element writes outside the store are dropped
  assign in_range = (int'(in_data.row) < MAX_DIM) && (int'(in_data.col) < MAX_DIM);
  assign wr_a     = accept && in_range && (in_data.action == ACT_WRITE_A);
  assign wr_b     = accept && in_range && (in_data.action == ACT_WRITE_B);
  assign wr_addr  = ADDR_W'(int'(in_data.row) * MAX_DIM + int'(in_data.col));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_RESET;
      inner_dim_r <= CFG_RESET;
      cols_b_r    <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[wr_addr] <= in_data.value;
    end
    if (wr_b) begin
      store_b[wr_addr] <= in_data.value;
    end
  end

  // a new (i,j) group starts only once the pipeline and the output are empty,
  // so its result can always land in the output register
  assign issue = (state_r == ST_MAC) &&
                 ((k_r != '0) || (!v1_r && !v2_r && !out_valid_r));

  assign rd_addr_a = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign rd_addr_b = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  assign i_ext = {2'b00, i_r};
  assign j_ext = {2'b00, j_r};

  always_comb begin
    tag_issue.first   = (k_r == '0);
    tag_issue.last_k  = (k_r == klim_r);
    tag_issue.last_el = (i_r == ilim_r) && (j_r == jlim_r);
    tag_issue.row     = i_ext[FIELD_W-1:0];
    tag_issue.col     = j_ext[FIELD_W-1:0];
  end

  // sequencer: walks i, j, k over the shared multiplier
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ilim_nxt  = ilim_r;
    jlim_nxt  = jlim_r;
    klim_nxt  = klim_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.action == ACT_START)) begin
          ilim_nxt  = dim_limit(rows_a_r);
          klim_nxt  = dim_limit(inner_dim_r);
          jlim_nxt  = dim_limit(cols_b_r);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (issue) begin
          if (k_r == klim_r) begin
            k_nxt = '0;
            if (j_r == jlim_r) begin
              j_nxt = '0;
              if (i_r == ilim_r) begin
                state_nxt = ST_IDLE;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ilim_r <= ilim_nxt;
    jlim_r <= jlim_nxt;
    klim_r <= klim_nxt;
  end

  // stage 1: registered store reads
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_a_r <= store_a[rd_addr_a];
      rd_b_r <= store_b[rd_addr_b];
      tag1_r <= tag_issue;
    end
  end

  // stage 2: multiply
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= rd_a_r * rd_b_r;
      tag2_r <= tag1_r;
    end
  end

  // stage 3: accumulate, exact in 34 bits
  assign acc_nxt = tag2_r.first ? RESULT_W'(prod_r) : acc_r + RESULT_W'(prod_r);

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
    if (v2_r && tag2_r.last_k) begin
      out_r.product <= acc_nxt;
      out_r.out_row <= tag2_r.row;
      out_r.out_col <= tag2_r.col;
      out_r.last    <= tag2_r.last_el;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (v2_r && tag2_r.last_k) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
